@@ design/ptt_pkg.sv @@
// Shared types and constants of the periodic timer table.
// Used by the controller, the datapath and the top level. No dependencies.
package ptt_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = 17;

    typedef enum logic [2:0] {
        FN_CREATE = 3'd0,
        FN_START  = 3'd1,
        FN_RESET  = 3'd2,
        FN_STOP   = 3'd3,
        FN_DELETE = 3'd4,
        FN_TICK   = 3'd5
    } t_func;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       apply;
        logic       emit_exp;
        logic       set_res;
        logic [1:0] res;
        logic       emit_fin;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       hit;
        logic       exp;
        logic       last;
        logic       out_free;
    } t_dp_sts;

endpackage

@@ design/periodic_timer_table_top.sv @@
// Top level of the periodic timer table: controller and datapath.
// Depends on ptt_pkg, ptt_ctrl and ptt_dp.
//
//   channel   direction  handshake           payload
//   command   in         i_valid / o_stall   i_func, i_tmr_id, i_period, i_arg_*, i_handler_tag
//   record    out        o_valid / i_stall   o_status, o_expired, o_out_*, o_last
//
// A tick walks all SLOTS entries one per cycle, but waits while an expiry record
// finds the record port stalled; it then places the status record.
// Create walks to the first free slot; start, reset, stop, delete to the slot with the id.
// Reset is synchronous and active low; it frees every slot and sets the id counter to one.
// A stalled record holds its register; the walk waits only when it must place another one.
module periodic_timer_table_top import ptt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_tmr_id,
    input  logic [15:0] i_period,
    input  logic [31:0] i_arg_one,
    input  logic [31:0] i_arg_two,
    input  logic [7:0]  i_handler_tag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_expired,
    output logic [31:0] o_out_id,
    output logic [31:0] o_out_arg_one,
    output logic [31:0] o_out_arg_two,
    output logic [7:0]  o_out_tag,
    output logic        o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    ptt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_stall)
    );

    ptt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_func),
        .i_tmr_id      (i_tmr_id),
        .i_period      (i_period),
        .i_arg_one     (i_arg_one),
        .i_arg_two     (i_arg_two),
        .i_handler_tag (i_handler_tag),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_expired     (o_expired),
        .o_out_id      (o_out_id),
        .o_out_arg_one (o_out_arg_one),
        .o_out_arg_two (o_out_arg_two),
        .o_out_tag     (o_out_tag),
        .o_last        (o_last)
    );

endmodule

@@ design/ptt_ctrl.sv @@
// Controller state machine of the periodic timer table.
// Depends on ptt_pkg; drives the datapath through t_dp_cmd.
module ptt_ctrl import ptt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                priority if (i_sts.func == FN_TICK) begin
                    if (!i_sts.exp || i_sts.out_free) begin
                        o_cmd.apply    = 1'b1;
                        o_cmd.emit_exp = i_sts.exp;
                        if (i_sts.last) begin
                            o_cmd.set_res = 1'b1;
                            o_cmd.res     = ST_OK;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.step = 1'b1;
                        end
                    end
                end else if (i_sts.func <= FN_DELETE) begin
                    if (i_sts.hit) begin
                        o_cmd.apply   = 1'b1;
                        o_cmd.set_res = 1'b1;
                        o_cmd.res     = ST_OK;
                        n_state       = S_DONE;
                    end else if (i_sts.last) begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res     = (i_sts.func == FN_CREATE) ? ST_FULL : ST_MISS;
                        n_state       = S_DONE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end else begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = ST_MISS;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_fin = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("final record sent but controller did not return to idle");

    a_walk_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_WALK))
        else $error("accepted transaction did not start a walk");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy)
        else $error("input loaded while busy");

endmodule

@@ design/ptt_dp.sv @@
// Datapath of the periodic timer table: input latch, slot table, walk index,
// id counter and output record register. Depends on ptt_pkg.
module ptt_dp import ptt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_tmr_id,
    input  logic [15:0] i_period,
    input  logic [31:0] i_arg_one,
    input  logic [31:0] i_arg_two,
    input  logic [7:0]  i_handler_tag,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_expired,
    output logic [31:0] o_out_id,
    output logic [31:0] o_out_arg_one,
    output logic [31:0] o_out_arg_two,
    output logic [7:0]  o_out_tag,
    output logic        o_last
);

    logic [SLOTS-1:0] r_used;
    logic [31:0]      r_slot_id    [SLOTS];
    logic [15:0]      r_slot_period[SLOTS];
    logic [CNT_W-1:0] r_slot_count [SLOTS];
    logic             r_slot_run   [SLOTS];
    logic [63:0]      r_slot_words [SLOTS];
    logic [7:0]       r_slot_tag   [SLOTS];

    logic [SLOT_W-1:0] r_idx;
    logic [2:0]        r_func;
    logic [31:0]       r_tid;
    logic [15:0]       r_period;
    logic [31:0]       r_a1;
    logic [31:0]       r_a2;
    logic [7:0]        r_tag;
    logic [31:0]       r_next_id;
    logic [31:0]       r_ret_id;
    logic [1:0]        r_res;

    logic        r_o_valid;
    logic [1:0]  r_o_status;
    logic        r_o_expired;
    logic [31:0] r_o_id;
    logic [31:0] r_o_a1;
    logic [31:0] r_o_a2;
    logic [7:0]  r_o_tag;
    logic        r_o_last;

    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] dec_cnt;
    logic [CNT_W-1:0] reload;
    logic             tick_act;
    logic             tick_exp;
    logic             out_free;

    always_comb begin
        cur_cnt  = r_slot_count[r_idx];
        reload   = {1'b0, r_slot_period[r_idx]};
        dec_cnt  = (cur_cnt != '0 && !cur_cnt[CNT_W-1]) ? cur_cnt - CNT_W'(1) : cur_cnt;
        tick_act = r_used[r_idx] && r_slot_run[r_idx];
        tick_exp = tick_act && (dec_cnt == '0);
        out_free = !r_o_valid || !i_stall;

        o_sts.func     = r_func;
        o_sts.hit      = (r_func == FN_CREATE) ? !r_used[r_idx]
                                               : (r_used[r_idx] && r_slot_id[r_idx] == r_tid);
        o_sts.exp      = tick_exp;
        o_sts.last     = (r_idx == SLOT_W'(SLOTS - 1));
        o_sts.out_free = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_next_id <= 32'd1;
        end else if (i_cmd.apply) begin
            if (r_func == FN_CREATE) begin
                r_used[r_idx] <= 1'b1;
                r_next_id     <= r_next_id + 32'd1;
            end else if (r_func == FN_TICK && tick_act && !tick_exp && (&dec_cnt)) begin
                r_used[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            unique case (r_func)
                FN_CREATE: begin
                    r_slot_id[r_idx]     <= r_next_id;
                    r_slot_period[r_idx] <= r_period;
                    r_slot_count[r_idx]  <= {1'b0, r_period};
                    r_slot_run[r_idx]    <= 1'b0;
                    r_slot_words[r_idx]  <= {r_a2, r_a1};
                    r_slot_tag[r_idx]    <= r_tag;
                end
                FN_START: begin
                    r_slot_run[r_idx] <= 1'b1;
                end
                FN_RESET: begin
                    r_slot_count[r_idx] <= reload;
                end
                FN_STOP: begin
                    r_slot_run[r_idx]   <= 1'b0;
                    r_slot_count[r_idx] <= reload;
                end
                FN_DELETE: begin
                    r_slot_count[r_idx] <= '1;
                end
                FN_TICK: begin
                    if (tick_act) begin
                        r_slot_count[r_idx] <= tick_exp ? reload : dec_cnt;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_func;
            r_tid    <= i_tmr_id;
            r_period <= i_period;
            r_a1     <= i_arg_one;
            r_a2     <= i_arg_two;
            r_tag    <= i_handler_tag;
            r_idx    <= '0;
            r_ret_id <= '0;
        end else begin
            if (i_cmd.step) begin
                r_idx <= r_idx + SLOT_W'(1);
            end
            if (i_cmd.apply && r_func == FN_CREATE) begin
                r_ret_id <= r_next_id;
            end
        end
        if (i_cmd.set_res) begin
            r_res <= i_cmd.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit_exp || i_cmd.emit_fin) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_exp) begin
            r_o_status  <= ST_OK;
            r_o_expired <= 1'b1;
            r_o_id      <= r_slot_id[r_idx];
            r_o_a1      <= r_slot_words[r_idx][31:0];
            r_o_a2      <= r_slot_words[r_idx][63:32];
            r_o_tag     <= r_slot_tag[r_idx];
            r_o_last    <= 1'b0;
        end else if (i_cmd.emit_fin) begin
            r_o_status  <= r_res;
            r_o_expired <= 1'b0;
            r_o_id      <= r_ret_id;
            r_o_a1      <= '0;
            r_o_a2      <= '0;
            r_o_tag     <= '0;
            r_o_last    <= 1'b1;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_expired     = r_o_expired;
    assign o_out_id      = r_o_id;
    assign o_out_arg_one = r_o_a1;
    assign o_out_arg_two = r_o_a2;
    assign o_out_tag     = r_o_tag;
    assign o_last        = r_o_last;

    a_exp_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_exp |-> out_free)
        else $error("expiry record would overwrite a waiting record");

    a_fin_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_fin |-> (out_free && !i_cmd.emit_exp))
        else $error("status record would overwrite a waiting record");

    a_id_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && r_func == FN_CREATE) |=> (r_next_id == $past(r_next_id) + 32'd1))
        else $error("id counter did not advance on create");

endmodule
